// File: rtl/core/svpc_pkg.sv
// svpc_pkg: widths, constants and item types for the space vector pwm compare block
// no dependencies; used by every other file of the block
`default_nettype none

package svpc_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int CMP_W       = 16;
  localparam int NUM_PH      = 3;

  // sqrt(3) in Q16
  localparam int               SQRT3_W   = 17;
  localparam logic [SQRT3_W-1:0] SQRT3_Q16 = 17'd113512;

  // configuration register widths
  localparam int DTV_W      = 12;
  localparam int SLOPE_W    = 16;
  localparam int PER_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DTV_W-1:0] DTV_RESET   = '0;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = '0;
  localparam logic [PER_W-1:0] PER_RESET   = 16'd4096;

  // internal datapath widths
  localparam int V_W   = VALUE_WIDTH + 11;          // doubled phase voltage, 2^-17 V
  localparam int B_W   = VALUE_WIDTH + SQRT3_W + 1; // beta * sqrt3
  localparam int C_W   = VALUE_WIDTH + SLOPE_W + 1; // current * slope
  localparam int U_W   = V_W + 3;                   // duty numerator, 2^-18 V
  localparam int N_W   = U_W + PER_W + 1;           // numerator * period
  localparam int D_W   = VALUE_WIDTH + 10;          // bus * 1024
  localparam int REM_W = N_W - 1;
  localparam int Q_W   = CMP_W;

  // pipeline: product, phase sum, injection, multiply, range check,
  // one stage per quotient bit, output register
  localparam int FRONT_STAGES = 3;
  localparam int NUM_STAGES   = FRONT_STAGES + 2 + Q_W + 1;
  localparam int DIV_EN_W     = NUM_STAGES - FRONT_STAGES;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEAD_VOLTS = 2'd0,
    CFG_DEAD_SLOPE = 2'd1,
    CFG_PWM_PERIOD = 2'd2
  } cfg_addr_t;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH-1:0]        uvalue_t;
  typedef logic signed [V_W-1:0]         volt_t;
  typedef logic signed [U_W-1:0]         ext_t;
  typedef logic [CMP_W-1:0]              cmp_t;

  typedef struct packed {
    value_t  volt_alpha;
    value_t  volt_beta;
    uvalue_t bus_volts;
    value_t  current_a;
    value_t  current_b;
    value_t  current_c;
  } cmd_t;

  typedef struct packed {
    cmp_t compare_a;
    cmp_t compare_b;
    cmp_t compare_c;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/svpc_in_if.sv
// svpc_in_if: command channel carrying voltage command, bus voltage and currents
// depends on svpc_pkg
`default_nettype none

interface svpc_in_if;
  import svpc_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/svpc_out_if.sv
// svpc_out_if: result channel carrying the three timer compare counts
// depends on svpc_pkg
`default_nettype none

interface svpc_out_if;
  import svpc_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/svpc_cfg_if.sv
// svpc_cfg_if: register write channel, address and write data
// depends on svpc_pkg
`default_nettype none

interface svpc_cfg_if;
  import svpc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/core/svpc_clarke.sv
// svpc_clarke: inverse clarke transform to three doubled phase voltages
// depends on svpc_pkg; one register stage, phase outputs combinational after it
`default_nettype none

module svpc_clarke (
  input  logic              clk,
  input  logic              en,
  input  svpc_pkg::value_t  alpha,
  input  svpc_pkg::value_t  beta,
  output svpc_pkg::volt_t   v [svpc_pkg::NUM_PH]
);
  import svpc_pkg::*;

  value_t              alpha_r;
  logic signed [B_W-1:0] bprod;
  volt_t               af;
  volt_t               sf;

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r <= alpha;
      bprod   <= B_W'(beta) * B_W'($signed({1'b0, SQRT3_Q16}));
    end
  end

  // alpha in 2^-16 V, sqrt3*beta floored to 2^-16 V
  assign af = {{(V_W - VALUE_WIDTH - 8){alpha_r[VALUE_WIDTH-1]}}, alpha_r, 8'b0};
  assign sf = V_W'(bprod >>> 8);

  assign v[0] = af <<< 1;
  assign v[1] = sf - af;
  assign v[2] = -af - sf;

endmodule

`default_nettype wire

// File: rtl/core/svpc_comp_lane.sv
// svpc_comp_lane: dead-time compensation for one phase, current times slope, clamped
// depends on svpc_pkg; two register stages (product, phase sum)
`default_nettype none

module svpc_comp_lane (
  input  logic                        clk,
  input  logic                        en_prod,
  input  logic                        en_sum,
  input  svpc_pkg::value_t            current,
  input  logic [svpc_pkg::DTV_W-1:0]   dead_volts,
  input  logic [svpc_pkg::SLOPE_W-1:0] dead_slope,
  input  svpc_pkg::volt_t             v_phase,
  output svpc_pkg::volt_t             w
);
  import svpc_pkg::*;

  logic signed [C_W-1:0] cprod;
  logic signed [C_W-1:0] lim_s;
  logic signed [C_W-1:0] comp;

  always_ff @(posedge clk) begin
    if (en_prod) begin
      cprod <= C_W'(current) * C_W'($signed({1'b0, dead_slope}));
    end
  end

  assign lim_s = $signed(C_W'({dead_volts, 8'b0}));

  always_comb begin
    comp = cprod;
    if (cprod > lim_s) begin
      comp = lim_s;
    end else if (cprod < -lim_s) begin
      comp = -lim_s;
    end
  end

  // compensation term is in 2^-16 V, phase voltage is doubled
  always_ff @(posedge clk) begin
    if (en_sum) begin
      w <= v_phase + (V_W'(comp) <<< 1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/svpc_merge.sv
// svpc_merge: min-max zero-sequence injection across the three lanes plus half-bus offset
// depends on svpc_pkg; one register stage
`default_nettype none

module svpc_merge (
  input  logic              clk,
  input  logic              en,
  input  svpc_pkg::volt_t   w [svpc_pkg::NUM_PH],
  input  svpc_pkg::uvalue_t bus,
  output svpc_pkg::ext_t    u [svpc_pkg::NUM_PH]
);
  import svpc_pkg::*;

  volt_t mx;
  volt_t mn;
  ext_t  mid;
  ext_t  half;
  ext_t  u_next [NUM_PH];

  always_comb begin
    mx = w[0];
    mn = w[0];
    for (int k = 1; k < NUM_PH; k++) begin
      if (w[k] > mx) begin
        mx = w[k];
      end
      if (w[k] < mn) begin
        mn = w[k];
      end
    end
  end

  assign mid  = U_W'(mx) + U_W'(mn);
  assign half = $signed(U_W'({bus, 9'b0}));

  always_comb begin
    for (int k = 0; k < NUM_PH; k++) begin
      u_next[k] = (U_W'(w[k]) <<< 1) - mid + half;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_PH; k++) begin
        u[k] <= u_next[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/svpc_div_lane.sv
// svpc_div_lane: one phase, numerator times period, pipelined restoring divide by bus*1024,
// then clamp to 1..period-1 (1 when period is below 2); depends on svpc_pkg
`default_nettype none

module svpc_div_lane (
  input  logic                         clk,
  input  logic [svpc_pkg::DIV_EN_W-1:0] en,
  input  svpc_pkg::ext_t               u,
  input  svpc_pkg::uvalue_t            bus,
  input  logic [svpc_pkg::PER_W-1:0]    period,
  output svpc_pkg::cmp_t               compare
);
  import svpc_pkg::*;

  localparam int EN_MUL  = 0;
  localparam int EN_FLAG = 1;
  localparam int EN_STEP = 2;
  localparam int EN_OUT  = DIV_EN_W - 1;

  logic signed [N_W-1:0] prod;
  logic signed [N_W-1:0] prod_r;
  uvalue_t               bus_m;
  logic [D_W-1:0]        dvs_m;
  logic                  small_c;
  logic                  ovf_c;

  logic [REM_W-1:0] rem_p   [Q_W+1];
  logic [Q_W-1:0]   q_p     [Q_W+1];
  logic             small_p [Q_W+1];
  logic             ovf_p   [Q_W+1];
  uvalue_t          bus_p   [Q_W+1];
  logic [REM_W-1:0] dsh     [Q_W];
  logic             take    [Q_W];

  logic [PER_W-1:0] lim;
  cmp_t             cmp_next;

  assign prod = N_W'(u) * N_W'($signed({1'b0, period}));

  always_ff @(posedge clk) begin
    if (en[EN_MUL]) begin
      prod_r <= prod;
      bus_m  <= bus;
    end
  end

  // quotient below one, or at least 2^Q_W (saturates to period-1)
  assign dvs_m   = {bus_m, 10'b0};
  assign small_c = prod_r < $signed(N_W'(dvs_m));
  assign ovf_c   = prod_r[REM_W-1:0] >= (REM_W'(dvs_m) << Q_W);

  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      dsh[j]  = REM_W'({bus_p[j], 10'b0}) << (Q_W - 1 - j);
      take[j] = rem_p[j] >= dsh[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en[EN_FLAG]) begin
      rem_p[0]   <= prod_r[REM_W-1:0];
      q_p[0]     <= '0;
      small_p[0] <= small_c;
      ovf_p[0]   <= ovf_c;
      bus_p[0]   <= bus_m;
    end
    for (int j = 0; j < Q_W; j++) begin
      if (en[EN_STEP + j]) begin
        rem_p[j+1]   <= take[j] ? rem_p[j] - dsh[j] : rem_p[j];
        q_p[j+1]     <= q_p[j] | (Q_W'(take[j]) << (Q_W - 1 - j));
        small_p[j+1] <= small_p[j];
        ovf_p[j+1]   <= ovf_p[j];
        bus_p[j+1]   <= bus_p[j];
      end
    end
  end

  assign lim = period - PER_W'(1);

  always_comb begin
    if (bus_p[Q_W] == '0 || small_p[Q_W] || period < PER_W'(2)) begin
      cmp_next = CMP_W'(1);
    end else if (ovf_p[Q_W] || q_p[Q_W] > lim) begin
      cmp_next = lim;
    end else if (q_p[Q_W] == '0) begin
      cmp_next = CMP_W'(1);
    end else begin
      cmp_next = q_p[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[EN_OUT]) begin
      compare <= cmp_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/space_vector_pwm_compare_top.sv
// Space vector PWM compare generator with min-max zero-sequence injection.
// Channels: cmd (sink) takes volt_alpha, volt_beta, bus_volts and three phase
// currents; result (source) gives compare_a/b/c; cfg (sink) writes
// dead_time_volts (addr 0), dead_time_slope (addr 1), pwm_period (addr 2),
// other addresses are dropped. cfg is always ready; write it only when idle.
// Throughput: one item per clock unless a full pipeline waits on result.ready.
// Depth: 22 stages from cmd transfer to result valid, set by the divider of
// each phase lane: one quotient bit per stage (16 stages) after multiply and range check.
// Three phase lanes run side by side; the injection stage merges them.
// Stall: every stage holds its own valid bit, so while a result waits on
// result.ready the pipeline keeps taking commands until all stages are full.
// Reset (rst, synchronous): all stage valid bits clear, the registers return
// to dead_time_volts 0, dead_time_slope 0, pwm_period 4096.
// Zero bus voltage gives compare 1 on all phases.
// Depends on svpc_pkg, the channel interfaces and the lane modules.
`default_nettype none

module space_vector_pwm_compare_top (
  input  logic              clk,
  input  logic              rst,
  svpc_in_if.sink           cmd,
  svpc_out_if.source        result,
  svpc_cfg_if.sink          cfg
);
  import svpc_pkg::*;

  logic [DTV_W-1:0]   dead_volts;
  logic [SLOPE_W-1:0] dead_slope;
  logic [PER_W-1:0]   pwm_period;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] rdy;
  logic                  out_free;

  uvalue_t bus_s0;
  uvalue_t bus_s1;
  uvalue_t bus_s2;
  value_t  cur [NUM_PH];
  volt_t   v   [NUM_PH];
  volt_t   w   [NUM_PH];
  ext_t    u   [NUM_PH];
  cmp_t    cmp [NUM_PH];

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_volts <= DTV_RESET;
      dead_slope <= SLOPE_RESET;
      pwm_period <= PER_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_DEAD_VOLTS: dead_volts <= cfg.wdata[DTV_W-1:0];
        CFG_DEAD_SLOPE: dead_slope <= cfg.wdata[SLOPE_W-1:0];
        CFG_PWM_PERIOD: pwm_period <= cfg.wdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage may load when the output is free or a bubble sits at or after it
  assign out_free = !vld[NUM_STAGES-1] || result.ready;

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      rdy[k] = out_free ||
               ((vld | ((NUM_STAGES'(1) << k) - NUM_STAGES'(1))) != '1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? cmd.valid : vld[k - 1];
        end
      end
    end
  end

  assign cmd.ready    = rdy[0];
  assign result.valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      bus_s0 <= cmd.data.bus_volts;
    end
    if (rdy[1]) begin
      bus_s1 <= bus_s0;
    end
    if (rdy[2]) begin
      bus_s2 <= bus_s1;
    end
  end

  assign cur[0] = cmd.data.current_a;
  assign cur[1] = cmd.data.current_b;
  assign cur[2] = cmd.data.current_c;

  svpc_clarke u_clarke (
    .clk   (clk),
    .en    (rdy[0]),
    .alpha (cmd.data.volt_alpha),
    .beta  (cmd.data.volt_beta),
    .v     (v)
  );

  for (genvar p = 0; p < NUM_PH; p++) begin : g_comp
    svpc_comp_lane u_comp (
      .clk        (clk),
      .en_prod    (rdy[0]),
      .en_sum     (rdy[1]),
      .current    (cur[p]),
      .dead_volts (dead_volts),
      .dead_slope (dead_slope),
      .v_phase    (v[p]),
      .w          (w[p])
    );
  end

  svpc_merge u_merge (
    .clk (clk),
    .en  (rdy[2]),
    .w   (w),
    .bus (bus_s1),
    .u   (u)
  );

  for (genvar p = 0; p < NUM_PH; p++) begin : g_div
    svpc_div_lane u_div (
      .clk     (clk),
      .en      (rdy[NUM_STAGES-1:FRONT_STAGES]),
      .u       (u[p]),
      .bus     (bus_s2),
      .period  (pwm_period),
      .compare (cmp[p])
    );
  end

  assign result.data.compare_a = cmp[0];
  assign result.data.compare_b = cmp[1];
  assign result.data.compare_c = cmp[2];

endmodule

`default_nettype wire

// File: rtl/core/svpc_checker.sv
// svpc_checker: port-level checks on the result and cmd channels, bound to the top level
// depends on svpc_pkg and space_vector_pwm_compare_top
`default_nettype none

module svpc_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_ready,
  input logic           res_valid,
  input logic           res_ready,
  input svpc_pkg::cmp_t cmp_a,
  input svpc_pkg::cmp_t cmp_b,
  input svpc_pkg::cmp_t cmp_c
);

  // a stalled result keeps its valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(cmp_a) && $stable(cmp_b) && $stable(cmp_c))
    else $error("result payload changed while stalled");

  // compare counts are clamped to at least one
  a_min_one: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> cmp_a != '0 && cmp_b != '0 && cmp_c != '0)
    else $error("compare count below one");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid && cmd_ready)
    else $error("pipeline not empty after reset");

endmodule

bind space_vector_pwm_compare_top svpc_checker u_svpc_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .cmp_a     (result.data.compare_a),
  .cmp_b     (result.data.compare_b),
  .cmp_c     (result.data.compare_c)
);

`default_nettype wire

// File: sim/tb_space_vector_pwm_compare_top.sv
// tb_space_vector_pwm_compare_top: self-checking bench for the space vector pwm compare block
// predicts compare counts per command and checks them in order; random gaps on both channels
// depends on svpc_pkg, svpc_in_if, svpc_out_if, svpc_cfg_if and space_vector_pwm_compare_top
module tb_space_vector_pwm_compare_top;
  timeunit 1ns;
  timeprecision 1ps;
  import svpc_pkg::*;

  localparam longint ROOT3_Q16 = 113512;
  localparam int STALL_LIMIT = 1000;
  localparam int END_CYCLES = 44;
  localparam int MAX_GAP = 8;
  localparam int PHASE_CMDS = 65;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  svpc_in_if  cmd_ch ();
  svpc_out_if result_ch ();
  svpc_cfg_if cfg_ch ();

  space_vector_pwm_compare_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  // register copies, as left by reset
  longint limit_volts = 0;
  longint comp_slope = 0;
  longint period_count = 4096;

  result_t compares_due [$];
  bit jitter = 1'b1;
  int mismatches = 0;
  int cmds_sent = 0;
  int zero_bus_cmds = 0;
  int compares_seen = 0;
  int reg_writes = 0;
  int stall_cycles = 0;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // current times slope, clamped to the compensation limit (2^-16 V)
  function automatic longint dead_time_term(longint cur);
    longint lim;
    longint t;
    lim = limit_volts * 256;
    t = cur * comp_slope;
    if (t > lim) return lim;
    if (t < -lim) return -lim;
    return t;
  endfunction

  function automatic cmp_t compare_count(longint num, longint bus);
    longint q;
    q = floor_div(num * period_count, bus * 1024);
    if (q > period_count - 1) q = period_count - 1;
    if (q < 1) q = 1;
    return q[CMP_W-1:0];
  endfunction

  function automatic result_t predict_compares(cmd_t c);
    longint bus;
    longint af;
    longint sf;
    longint mx;
    longint mn;
    longint w [NUM_PH];
    cmp_t cnt [NUM_PH];
    result_t r;
    bus = longint'(c.bus_volts);
    if (bus == 0) begin
      r.compare_a = cmp_t'(1);
      r.compare_b = cmp_t'(1);
      r.compare_c = cmp_t'(1);
      return r;
    end
    // doubled phase voltages in 2^-17 V
    af = longint'($signed(c.volt_alpha)) * 256;
    sf = floor_div(longint'($signed(c.volt_beta)) * ROOT3_Q16, 256);
    w[0] = 2 * af + 2 * dead_time_term(longint'($signed(c.current_a)));
    w[1] = -af + sf + 2 * dead_time_term(longint'($signed(c.current_b)));
    w[2] = -af - sf + 2 * dead_time_term(longint'($signed(c.current_c)));
    mx = w[0];
    mn = w[0];
    for (int k = 1; k < NUM_PH; k++) begin
      if (w[k] > mx) mx = w[k];
      if (w[k] < mn) mn = w[k];
    end
    for (int k = 0; k < NUM_PH; k++) begin
      cnt[k] = compare_count(2 * w[k] - (mx + mn) + bus * 512, bus);
    end
    r.compare_a = cnt[0];
    r.compare_b = cnt[1];
    r.compare_c = cnt[2];
    return r;
  endfunction

  function automatic cmd_t make_cmd(uvalue_t alpha, uvalue_t beta, uvalue_t bus,
                                    uvalue_t ia, uvalue_t ib, uvalue_t ic);
    cmd_t c;
    c.volt_alpha = alpha;
    c.volt_beta  = beta;
    c.bus_volts  = bus;
    c.current_a  = ia;
    c.current_b  = ib;
    c.current_c  = ic;
    return c;
  endfunction

  // mostly commands within the bus range, the rest raw bits
  function automatic cmd_t random_cmd();
    cmd_t c;
    int span;
    c = {$urandom(), $urandom(), $urandom()};
    if ($urandom_range(0, 9) < 7) begin
      c.bus_volts  = uvalue_t'($urandom_range(1, 65535));
      span         = int'(c.bus_volts) / 2;
      c.volt_alpha = value_t'($urandom_range(0, 2 * span) - span);
      c.volt_beta  = value_t'($urandom_range(0, 2 * span) - span);
      c.current_a  = value_t'($urandom_range(0, 4095) - 2048);
      c.current_b  = value_t'($urandom_range(0, 4095) - 2048);
      c.current_c  = value_t'($urandom_range(0, 4095) - 2048);
    end
    if ($urandom_range(0, 31) == 0) c.bus_volts = '0;
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 20) $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_cmd(cmd_t c);
    int gap;
    gap = jitter ? $urandom_range(0, MAX_GAP) : 0;
    cfg_ch.valid <= 1'b0;
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    compares_due.push_back(predict_compares(c));
    cmds_sent++;
    if (c.bus_volts == 0) zero_bus_cmds++;
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (compares_due.size() != 0) @(posedge clk);
  endtask

  // register writes only once the pipeline has emptied
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.wdata <= data;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    reg_writes++;
    case (addr)
      CFG_DEAD_VOLTS: limit_volts = longint'(data[DTV_W-1:0]);
      CFG_DEAD_SLOPE: comp_slope = longint'(data);
      CFG_PWM_PERIOD: period_count = longint'(data);
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_cmd(make_cmd(16'h1234, 16'hFA99, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001));
    send_cmd(make_cmd(16'h0000, 16'h0000, 16'h1800, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(make_cmd(16'h0100, 16'h0080, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_field_extremes();
    send_cmd(make_cmd(16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(make_cmd(16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(make_cmd(16'h0000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(make_cmd(16'h0000, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    // upper data bits of the 12-bit limit register are dropped
    write_reg(CFG_DEAD_VOLTS, 16'hFFFF);
    write_reg(CFG_DEAD_SLOPE, 16'hFFFF);
    send_cmd(make_cmd(16'h8000, 16'h8000, 16'h0001, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_cmd(make_cmd(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000));
  endtask

  task automatic test_dead_time_comp();
    write_reg(CFG_DEAD_VOLTS, 16'd2560);
    write_reg(CFG_DEAD_SLOPE, 16'h0100);
    // below the limit, then saturated both ways
    send_cmd(make_cmd(16'h0000, 16'h0000, 16'h1800, 16'h0100, 16'hFF00, 16'h0000));
    send_cmd(make_cmd(16'h0000, 16'h0000, 16'h1800, 16'h7FFF, 16'h8000, 16'h0A00));
    send_cmd(make_cmd(16'h0800, 16'hF800, 16'h2000, 16'h0300, 16'hFD00, 16'h0010));
  endtask

  task automatic test_unused_register();
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_cmd(make_cmd(16'h0400, 16'h0200, 16'h1800, 16'h0100, 16'h0000, 16'hFF00));
  endtask

  task automatic test_period_limits();
    write_reg(CFG_PWM_PERIOD, 16'd0);
    send_cmd(make_cmd(16'h0400, 16'hFC00, 16'h1800, 16'h0000, 16'h0000, 16'h0000));
    write_reg(CFG_PWM_PERIOD, 16'd1);
    send_cmd(make_cmd(16'hFC00, 16'h0400, 16'h1800, 16'h0000, 16'h0000, 16'h0000));
    write_reg(CFG_PWM_PERIOD, 16'd2);
    send_cmd(make_cmd(16'h0000, 16'h0000, 16'h1800, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(make_cmd(16'h0C00, 16'h0000, 16'h1800, 16'h0000, 16'h0000, 16'h0000));
    write_reg(CFG_PWM_PERIOD, 16'hFFFF);
    send_cmd(make_cmd(16'h0000, 16'h0000, 16'h1800, 16'h0000, 16'h0000, 16'h0000));
    send_cmd(make_cmd(16'h0A00, 16'hF600, 16'h1800, 16'h0200, 16'hFE00, 16'h0000));
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_DEAD_VOLTS, CFG_DATA_W'($urandom_range(0, 2560)));
          write_reg(CFG_DEAD_SLOPE, CFG_DATA_W'($urandom_range(0, 1023)));
          write_reg(CFG_PWM_PERIOD, 16'd4096);
        end
        1: begin
          write_reg(CFG_DEAD_VOLTS, 16'd2560);
          write_reg(CFG_DEAD_SLOPE, 16'hFFFF);
          write_reg(CFG_PWM_PERIOD, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_DEAD_VOLTS, CFG_DATA_W'($urandom()));
          write_reg(CFG_DEAD_SLOPE, CFG_DATA_W'($urandom()));
          write_reg(CFG_PWM_PERIOD, CFG_DATA_W'($urandom()));
        end
        3: begin
          write_reg(CFG_DEAD_VOLTS, CFG_DATA_W'($urandom_range(0, 4095)));
          write_reg(CFG_DEAD_SLOPE, CFG_DATA_W'($urandom()));
          write_reg(CFG_PWM_PERIOD, CFG_DATA_W'($urandom_range(2, 32)));
        end
        4: begin
          write_reg(CFG_DEAD_VOLTS, 16'd0);
          write_reg(CFG_DEAD_SLOPE, 16'd0);
          write_reg(CFG_PWM_PERIOD, CFG_DATA_W'($urandom_range(2, 65535)));
        end
        default: begin
          write_reg(CFG_DEAD_VOLTS, CFG_DATA_W'($urandom_range(0, 4095)));
          write_reg(CFG_DEAD_SLOPE, CFG_DATA_W'($urandom_range(0, 4095)));
          write_reg(CFG_PWM_PERIOD, CFG_DATA_W'($urandom_range(1000, 8000)));
        end
      endcase
      // two phases run back to back with no gaps on either side
      jitter = (phase != 1 && phase != 4);
      for (int n = 0; n < PHASE_CMDS; n++) begin
        if (n == PHASE_CMDS / 2 || $urandom_range(0, 59) == 0) wait_drained();
        send_cmd(random_cmd());
      end
    end
    jitter = 1'b1;
  endtask

  // result side: random stalls, in-order check against predicted counts
  initial begin : result_check
    result_t got;
    result_t want;
    cmp_t got_ph [NUM_PH];
    cmp_t want_ph [NUM_PH];
    int stall;
    wait (rst === 1'b0);
    forever begin
      stall = jitter ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (result_ch.valid !== 1'b1) @(posedge clk);
      got = result_ch.data;
      compares_seen++;
      if (compares_due.size() == 0) begin
        report_mismatch($sformatf("result %h with no command outstanding", got));
      end else begin
        want = compares_due.pop_front();
        got_ph = '{got.compare_a, got.compare_b, got.compare_c};
        want_ph = '{want.compare_a, want.compare_b, want.compare_c};
        for (int k = 0; k < NUM_PH; k++) begin
          if (got_ph[k] !== want_ph[k])
            report_mismatch($sformatf("result %0d phase %0d: got %0d, expected %0d",
                                      compares_seen, k, got_ph[k], want_ph[k]));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR %0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_space_vector_pwm_compare_top NOT OK");
      $finish;
    end
  end

  initial begin
    cmd_ch.valid    = 1'b0;
    cmd_ch.data     = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.addr     = '0;
    cfg_ch.wdata    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_field_extremes();
    test_dead_time_comp();
    test_unused_register();
    test_period_limits();
    test_random_mix();
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d commands (%0d at zero bus), %0d results, %0d register writes",
             cmds_sent, zero_bus_cmds, compares_seen, reg_writes);
    $display("settings ran from period 0 to 65535 with open and saturated dead-time terms");
    if (mismatches == 0 && compares_due.size() == 0) begin
      $display("tb_space_vector_pwm_compare_top OK");
    end else begin
      $display("tb_space_vector_pwm_compare_top NOT OK");
    end
    $finish;
  end

endmodule
